/* rtl/generational_slot_allocator_unit_assert.svh */
// Assertion macros used by the slot allocator datapath.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GSA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/gsa_pkg.sv */
// Types and constants of the generational slot allocator.
package gsa_pkg;

    localparam int SLOTS      = 8192;
    localparam int FREE_DEPTH = 8192;
    localparam int TYPES      = 16;
    localparam int GEN_BITS   = 16;
    localparam int TYPE_CAP   = 8192;

    localparam int SLOT_W  = 13;
    localparam int FREE_AW = 13;
    localparam int TOP_W   = 14;
    localparam int CNT_W   = 14;
    localparam int TYPE_W  = 4;
    localparam int CAP_W   = 14;
    localparam int CMD_W   = 2;
    localparam int ST_W    = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 14'd6000;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_RANGE     = 3'd1,
        ST_STALE     = 3'd2,
        ST_TYPE      = 3'd3,
        ST_NOSLOT    = 3'd4,
        ST_STACKFULL = 3'd5,
        ST_COUNT     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic [GEN_BITS-1:0] gen;
        logic [TYPE_W-1:0]   etype;
        logic [SLOT_W-1:0]   bidx;
    } slot_entry_t;

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic latch_slot;
        logic execute;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_status_t;

endpackage

/* rtl/generational_slot_allocator_unit.sv */
// Top level of the generational slot allocator: controller plus datapath.
//
//  channel   handshake            payload
//  command   start / busy         cmd, entity_type, slot_index, handle_generation
//  result    done (strobe)        status, out_slot, out_generation, out_type, buffer_index
//  config    cfg_we               cfg_wdata (slot_capacity)
//
// A transaction runs through the read step, the slot table read (address from the free stack
// top, read ahead while idle, or the fresh slot counter), then the execute step, check and
// write-back; done is registered from the execute step. A new transaction is accepted only
// in idle after the previous one's execute step, so transactions never overlap.
// After reset the slot table is cleared one entry per cycle, all 8192 entries, with busy high.
// Done is high for a single cycle; the result registers hold until the next execute step. The receiver cannot stall.
module generational_slot_allocator_unit
    import gsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [TYPE_W-1:0]   entity_type,
    input  logic [SLOT_W-1:0]   slot_index,
    input  logic [GEN_BITS-1:0] handle_generation,
    input  logic                cfg_we,
    input  logic [CAP_W-1:0]    cfg_wdata,
    output logic                done,
    output logic [ST_W-1:0]     status,
    output logic [SLOT_W-1:0]   out_slot,
    output logic [GEN_BITS-1:0] out_generation,
    output logic [TYPE_W-1:0]   out_type,
    output logic [SLOT_W-1:0]   buffer_index
);

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    gsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .dp_status (dp_status),
        .ctrl_cmd  (ctrl_cmd),
        .busy      (busy)
    );

    gsa_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl_cmd          (ctrl_cmd),
        .dp_status         (dp_status),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .cmd               (cmd),
        .entity_type       (entity_type),
        .slot_index        (slot_index),
        .handle_generation (handle_generation),
        .done              (done),
        .status            (status),
        .out_slot          (out_slot),
        .out_generation    (out_generation),
        .out_type          (out_type),
        .buffer_index      (buffer_index)
    );

endmodule

/* rtl/gsa_ctrl.sv */
// Controller state machine: clearing pass, transaction capture, read and execute steps.
module gsa_ctrl
    import gsa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  ctrl_cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (dp_status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl_cmd = '0;
        busy     = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                ctrl_cmd.clear_step = 1'b1;
            end
            S_IDLE:
            begin
                busy             = 1'b0;
                ctrl_cmd.capture = start;
            end
            S_READ:
            begin
                ctrl_cmd.latch_slot = 1'b1;
            end
            S_EXEC:
            begin
                ctrl_cmd.execute = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/gsa_datapath.sv */
// Datapath: slot table and free stack memories, type counters, checks and result registers.
`include "generational_slot_allocator_unit_assert.svh"

module gsa_datapath
    import gsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           ctrl_cmd,
    output dp_status_t          dp_status,
    input  logic                cfg_we,
    input  logic [CAP_W-1:0]    cfg_wdata,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [TYPE_W-1:0]   entity_type,
    input  logic [SLOT_W-1:0]   slot_index,
    input  logic [GEN_BITS-1:0] handle_generation,
    output logic                done,
    output logic [ST_W-1:0]     status,
    output logic [SLOT_W-1:0]   out_slot,
    output logic [GEN_BITS-1:0] out_generation,
    output logic [TYPE_W-1:0]   out_type,
    output logic [SLOT_W-1:0]   buffer_index
);

    slot_entry_t       slot_mem [SLOTS];
    logic [SLOT_W-1:0] stack_mem [FREE_DEPTH];

    slot_entry_t         slot_rdata_reg;
    logic [SLOT_W-1:0]   stack_rdata_reg;

    cmd_t                cmd_reg;
    logic [TYPE_W-1:0]   type_reg;
    logic [SLOT_W-1:0]   slot_in_reg;
    logic [GEN_BITS-1:0] hgen_reg;
    logic [SLOT_W-1:0]   sel_slot_reg;
    logic [CAP_W-1:0]    slot_cap_reg;
    logic [TOP_W-1:0]    free_top_reg;
    logic [TOP_W-1:0]    fresh_reg;
    logic [CNT_W-1:0]    type_count_reg [TYPES];
    logic [SLOT_W-1:0]   clr_cnt_reg;

    logic                done_reg;
    status_t             status_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [GEN_BITS-1:0] out_gen_reg;
    logic [TYPE_W-1:0]   out_type_reg;
    logic [SLOT_W-1:0]   bidx_reg;

    logic [CAP_W-1:0]    cap_eff;
    logic [SLOT_W-1:0]   sel_slot;
    logic [FREE_AW-1:0]  stack_raddr;
    logic [TOP_W-1:0]    top_minus1;
    logic [CNT_W-1:0]    cnt;
    logic                type_ok;
    logic                slot_in_range;
    logic [GEN_BITS-1:0] new_gen;

    status_t             res_status;
    logic [SLOT_W-1:0]   res_slot;
    logic [GEN_BITS-1:0] res_gen;
    logic [SLOT_W-1:0]   res_bidx;
    logic                slot_we;
    logic                do_push;
    logic                do_pop;
    logic                do_fresh;
    logic                cnt_inc;
    logic                cnt_dec;

    logic                mem_we;
    logic [SLOT_W-1:0]   mem_waddr;
    slot_entry_t         mem_wdata;

    assign cap_eff       = (slot_cap_reg > CAP_W'(SLOTS)) ? CAP_W'(SLOTS) : slot_cap_reg;
    assign top_minus1    = free_top_reg - TOP_W'(1);
    assign stack_raddr   = top_minus1[FREE_AW-1:0];
    assign cnt           = type_count_reg[type_reg];
    assign type_ok       = (32'(type_reg) < TYPES);
    assign slot_in_range = ({1'b0, slot_in_reg} < cap_eff);
    assign new_gen       = slot_rdata_reg.gen + GEN_BITS'(1);

    always_comb
    begin
        if (cmd_reg == CMD_ADD)
        begin
            sel_slot = (free_top_reg != '0) ? stack_rdata_reg : fresh_reg[SLOT_W-1:0];
        end
        else
        begin
            sel_slot = slot_in_reg;
        end
    end

    always_comb
    begin
        res_status = ST_OK;
        res_slot   = slot_in_reg;
        res_gen    = '0;
        res_bidx   = '0;
        slot_we    = 1'b0;
        do_push    = 1'b0;
        do_pop     = 1'b0;
        do_fresh   = 1'b0;
        cnt_inc    = 1'b0;
        cnt_dec    = 1'b0;
        case (cmd_reg)
            CMD_ADD:
            begin
                if (!type_ok)
                begin
                    res_status = ST_TYPE;
                end
                else if (cnt >= CNT_W'(TYPE_CAP))
                begin
                    res_status = ST_COUNT;
                end
                else if (free_top_reg == '0 && fresh_reg >= cap_eff)
                begin
                    res_status = ST_NOSLOT;
                end
                else
                begin
                    do_pop   = (free_top_reg != '0);
                    do_fresh = (free_top_reg == '0);
                    slot_we  = 1'b1;
                    cnt_inc  = 1'b1;
                    res_slot = sel_slot_reg;
                    res_gen  = new_gen;
                    res_bidx = cnt[SLOT_W-1:0];
                end
            end
            CMD_DELETE:
            begin
                if (!slot_in_range)
                begin
                    res_status = ST_RANGE;
                end
                else if (!type_ok)
                begin
                    res_status = ST_TYPE;
                end
                else if (free_top_reg >= TOP_W'(FREE_DEPTH))
                begin
                    res_status = ST_STACKFULL;
                end
                else if (cnt == '0)
                begin
                    res_status = ST_COUNT;
                end
                else
                begin
                    do_push = 1'b1;
                    cnt_dec = 1'b1;
                end
            end
            CMD_LOOKUP:
            begin
                if (!slot_in_range)
                begin
                    res_status = ST_RANGE;
                end
                else
                begin
                    res_gen = slot_rdata_reg.gen;
                    if (slot_rdata_reg.gen != hgen_reg)
                    begin
                        res_status = ST_STALE;
                    end
                    else if (!type_ok || slot_rdata_reg.etype != type_reg)
                    begin
                        res_status = ST_TYPE;
                    end
                    else
                    begin
                        res_bidx = slot_rdata_reg.bidx;
                    end
                end
            end
            default:
            begin
                res_status = ST_OK;
            end
        endcase
    end

    assign mem_we    = ctrl_cmd.clear_step | (ctrl_cmd.execute & slot_we);
    assign mem_waddr = ctrl_cmd.clear_step ? clr_cnt_reg : sel_slot_reg;
    always_comb
    begin
        mem_wdata = '0;
        if (!ctrl_cmd.clear_step)
        begin
            mem_wdata.gen   = new_gen;
            mem_wdata.etype = type_reg;
            mem_wdata.bidx  = cnt[SLOT_W-1:0];
        end
    end

    // slot table memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        slot_rdata_reg <= slot_mem[sel_slot];
    end

    // free stack memory, top entry read every cycle
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.execute && do_push)
        begin
            stack_mem[free_top_reg[FREE_AW-1:0]] <= slot_in_reg;
        end
        stack_rdata_reg <= stack_mem[stack_raddr];
    end

    // transaction capture, slot latch and result registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.capture)
        begin
            cmd_reg     <= cmd_t'(cmd);
            type_reg    <= entity_type;
            slot_in_reg <= slot_index;
            hgen_reg    <= handle_generation;
        end
        if (ctrl_cmd.latch_slot)
        begin
            sel_slot_reg <= sel_slot;
        end
        if (ctrl_cmd.execute)
        begin
            status_reg   <= res_status;
            out_slot_reg <= res_slot;
            out_gen_reg  <= res_gen;
            out_type_reg <= type_reg;
            bidx_reg     <= res_bidx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_cap_reg <= CAP_RESET;
            free_top_reg <= '0;
            fresh_reg    <= '0;
            clr_cnt_reg  <= '0;
            done_reg     <= 1'b0;
            for (int i = 0; i < TYPES; i++)
            begin
                type_count_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= ctrl_cmd.execute;
            if (cfg_we)
            begin
                slot_cap_reg <= cfg_wdata;
            end
            if (ctrl_cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
            end
            if (ctrl_cmd.execute)
            begin
                if (do_push)
                begin
                    free_top_reg <= free_top_reg + TOP_W'(1);
                end
                else if (do_pop)
                begin
                    free_top_reg <= top_minus1;
                end
                if (do_fresh)
                begin
                    fresh_reg <= fresh_reg + TOP_W'(1);
                end
                if (cnt_inc)
                begin
                    type_count_reg[type_reg] <= cnt + CNT_W'(1);
                end
                else if (cnt_dec)
                begin
                    type_count_reg[type_reg] <= cnt - CNT_W'(1);
                end
            end
        end
    end

    assign dp_status.clear_last = (clr_cnt_reg == SLOT_W'(SLOTS - 1));

    assign done           = done_reg;
    assign status         = status_reg;
    assign out_slot       = out_slot_reg;
    assign out_generation = out_gen_reg;
    assign out_type       = out_type_reg;
    assign buffer_index   = bidx_reg;

    `GSA_ASSERT_IMPL(a_top_bound, clk, rst_n, 1'b1, free_top_reg <= TOP_W'(FREE_DEPTH), "free stack top beyond depth")
    `GSA_ASSERT_IMPL(a_fresh_bound, clk, rst_n, 1'b1, fresh_reg <= TOP_W'(SLOTS), "fresh slot counter beyond slot count")
    `GSA_ASSERT_NEXT(a_exec_done, clk, rst_n, ctrl_cmd.execute, done_reg, "execute step without result strobe")
    `GSA_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg, "result strobe longer than one cycle")

endmodule
